// File: src/dnts_pkg.sv
// ----------------------------------------------------------------------------
// dnts_pkg
// Types, character codes and the power-of-ten table for the decimal number
// token scanner.
// ----------------------------------------------------------------------------
package dnts_pkg;

	typedef enum logic [3:0] {
		SCAN_IDLE    = 4'b0001,
		SCAN_COMMENT = 4'b0010,
		SCAN_NUMBER  = 4'b0100,
		SCAN_SLASH   = 4'b1000
	} scan_mode_t;

	typedef enum logic [2:0] {
		SEQ_READY = 3'b001,
		SEQ_DIV   = 3'b010,
		SEQ_PUSH  = 3'b100
	} seq_state_t;

	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_POINT   = 8'h2E;

	localparam logic [30:0] INT_MAX_VAL     = 31'h7FFF_FFFF;
	localparam logic [3:0]  MAX_FRAC_DIGITS = 4'd9;

	function automatic logic [29:0] pow10(input logic [3:0] n);
		logic [29:0] p;
		case (n)
			4'd0:    p = 30'd1;
			4'd1:    p = 30'd10;
			4'd2:    p = 30'd100;
			4'd3:    p = 30'd1000;
			4'd4:    p = 30'd10000;
			4'd5:    p = 30'd100000;
			4'd6:    p = 30'd1000000;
			4'd7:    p = 30'd10000000;
			4'd8:    p = 30'd100000000;
			default: p = 30'd1000000000;
		endcase
		return p;
	endfunction

endpackage

// File: src/decimal_number_token_scanner_unit.sv
// ----------------------------------------------------------------------------
// decimal_number_token_scanner_unit
// Scans text bytes for decimal number tokens, skipping // comments, and gives
// each token as a saturated integer and an unsigned fixed-point value, and marks a final byte that ends no token.
// ----------------------------------------------------------------------------
// A byte that extends or skips text is taken and leaves the input ready for the
// next byte. A byte that ends a token goes through the divider and the push step:
// the fraction digits are divided by a power of ten in a restoring divider that
// produces one quotient bit per cycle, and the result then moves to the output
// register. A final byte that ends no token goes straight to the push step. The
// input is not ready while the divider runs or a result waits for room in the output register.
module decimal_number_token_scanner_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        number_kind,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] int_value,
	output logic [31:0] fixed_value,
	output logic        ran_out,
	output logic        saturated
);
	import dnts_pkg::*;

	localparam int INT_BITS = 32 - FRAC_BITS;
	localparam int CNT_W    = $clog2(FRAC_BITS);
	localparam logic [30:0] INT_LIMIT = 31'((64'd1 << INT_BITS) - 64'd1);

	seq_state_t  seq_q;
	scan_mode_t  scan_q, scan_d;
	logic [30:0] tok_int_q, tok_int_d;
	logic [29:0] tok_frac_q, tok_frac_d;
	logic [3:0]  tok_cnt_q, tok_cnt_d;
	logic [1:0]  tok_pt_q, tok_pt_d;
	logic        tok_ovf_q, tok_ovf_d;
	logic        emit;

	logic [29:0]          div_rem_q;
	logic [29:0]          div_d_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [30:0]          res_int_q;
	logic                 res_big_q, res_sat_q, res_ranout_q;
	logic                 out_valid_q;

	logic        in_acc, is_dig, is_slash, start_idle, tok_big;
	logic [3:0]  dval;
	logic [34:0] int_mac;
	logic [33:0] frac_mac;
	logic [30:0] rem2;
	logic        ge;
	logic        push_go;

	assign in_ready = (seq_q == SEQ_READY);
	assign in_acc   = in_valid && in_ready;
	assign is_dig   = byte_value inside {[CH_ZERO:CH_NINE]};
	assign is_slash = (byte_value == CH_SLASH);
	assign dval     = 4'(byte_value - CH_ZERO);
	assign int_mac  = ({4'b0, tok_int_q} << 3) + ({4'b0, tok_int_q} << 1) + 35'(dval);
	assign frac_mac = ({4'b0, tok_frac_q} << 3) + ({4'b0, tok_frac_q} << 1) + 34'(dval);
	assign tok_big  = tok_ovf_q || (tok_int_q > INT_LIMIT);
	assign start_idle = (scan_q == SCAN_IDLE) || ((scan_q == SCAN_SLASH) && !is_slash);

	always_comb begin
		scan_d     = scan_q;
		tok_int_d  = tok_int_q;
		tok_frac_d = tok_frac_q;
		tok_cnt_d  = tok_cnt_q;
		tok_pt_d   = tok_pt_q;
		tok_ovf_d  = tok_ovf_q;
		emit       = 1'b0;
		if (scan_q == SCAN_COMMENT) begin
			if (byte_value == CH_NEWLINE) scan_d = SCAN_IDLE;
		end else if (scan_q == SCAN_NUMBER) begin
			if (is_dig) begin
				if (tok_pt_q == 2'd0) begin
					if (!tok_ovf_q) begin
						if (int_mac > {4'b0, INT_MAX_VAL}) begin
							tok_ovf_d = 1'b1;
							tok_int_d = INT_MAX_VAL;
						end else begin
							tok_int_d = int_mac[30:0];
						end
					end
				end else if (tok_pt_q == 2'd1 && tok_cnt_q < MAX_FRAC_DIGITS) begin
					tok_frac_d = frac_mac[29:0];
					tok_cnt_d  = tok_cnt_q + 4'd1;
				end
			end else if (byte_value == CH_POINT && number_kind) begin
				if (tok_pt_q != 2'd2) tok_pt_d = tok_pt_q + 2'd1;
			end else begin
				emit       = 1'b1;
				scan_d     = SCAN_IDLE;
				tok_int_d  = '0;
				tok_frac_d = '0;
				tok_cnt_d  = '0;
				tok_pt_d   = '0;
				tok_ovf_d  = 1'b0;
			end
		end else if (start_idle) begin
			if (is_slash) begin
				scan_d = SCAN_SLASH;
			end else if (is_dig) begin
				scan_d     = SCAN_NUMBER;
				tok_int_d  = 31'(dval);
				tok_frac_d = '0;
				tok_cnt_d  = '0;
				tok_pt_d   = '0;
				tok_ovf_d  = 1'b0;
			end else begin
				scan_d = SCAN_IDLE;
			end
		end else begin
			scan_d = SCAN_COMMENT;
		end
	end

	assign rem2    = {div_rem_q, 1'b0};
	assign ge      = (rem2 >= {1'b0, div_d_q});
	assign push_go = (seq_q == SEQ_PUSH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SEQ_READY;
			scan_q      <= SCAN_IDLE;
			tok_int_q   <= '0;
			tok_frac_q  <= '0;
			tok_cnt_q   <= '0;
			tok_pt_q    <= '0;
			tok_ovf_q   <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (seq_q)
				SEQ_READY: begin
					if (in_acc) begin
						if (is_last) begin
							scan_q     <= SCAN_IDLE;
							tok_int_q  <= '0;
							tok_frac_q <= '0;
							tok_cnt_q  <= '0;
							tok_pt_q   <= '0;
							tok_ovf_q  <= 1'b0;
						end else begin
							scan_q     <= scan_d;
							tok_int_q  <= tok_int_d;
							tok_frac_q <= tok_frac_d;
							tok_cnt_q  <= tok_cnt_d;
							tok_pt_q   <= tok_pt_d;
							tok_ovf_q  <= tok_ovf_d;
						end
						if (emit) begin
							seq_q <= SEQ_DIV;
							cnt_q <= CNT_W'(FRAC_BITS - 1);
						end else if (is_last) begin
							seq_q <= SEQ_PUSH;
						end
					end
				end
				SEQ_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) seq_q <= SEQ_PUSH;
				end
				SEQ_PUSH: begin
					if (push_go) seq_q <= SEQ_READY;
				end
				default: seq_q <= SEQ_READY;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			div_rem_q    <= tok_frac_q;
			div_d_q      <= pow10(tok_cnt_q);
			quot_q       <= '0;
			res_int_q    <= tok_int_q;
			res_big_q    <= tok_big;
			res_sat_q    <= number_kind ? tok_big : tok_ovf_q;
			res_ranout_q <= 1'b0;
		end else if (in_acc && is_last) begin
			div_rem_q    <= '0;
			div_d_q      <= 30'd1;
			quot_q       <= '0;
			res_int_q    <= '0;
			res_big_q    <= 1'b0;
			res_sat_q    <= 1'b0;
			res_ranout_q <= 1'b1;
		end else if (seq_q == SEQ_DIV) begin
			div_rem_q <= ge ? 30'(rem2 - {1'b0, div_d_q}) : rem2[29:0];
			quot_q    <= {quot_q[FRAC_BITS-2:0], ge};
		end
		if (push_go) begin
			int_value   <= res_int_q;
			fixed_value <= res_big_q ? '1 : {res_int_q[INT_BITS-1:0], quot_q};
			ran_out     <= res_ranout_q;
			saturated   <= res_sat_q;
		end
	end

	assign out_valid = out_valid_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SEQ_DIV) |-> (div_rem_q < div_d_q))
		else $error("divider remainder not below divisor");

	a_ranout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ran_out) |-> (int_value == '0 && fixed_value == '0 && !saturated))
		else $error("ran_out result carries nonzero fields");

	a_sat_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (fixed_value == '1))
		else $error("saturated result without all-ones fixed value");

	a_result_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(seq_q == SEQ_PUSH))
		else $error("result appeared without push step");

endmodule

// File: tb/tb_decimal_number_token_scanner_unit.sv
// ----------------------------------------------------------------------------
// tb_decimal_number_token_scanner_unit
// Feeds text bytes into the decimal number token scanner and checks every
// token result against a cycle-free prediction of the scanner. A short
// directed text covers comments, stray slashes, points, long fractions, large
// integer parts and buffer ends. Random text follows, built mostly from
// well-formed tokens and comments. Both sides idle at random, the receiver
// holds off for a long stretch once, and the sender drains between phases.
// ----------------------------------------------------------------------------
module tb_decimal_number_token_scanner_unit;
	import dnts_pkg::*;

	localparam int FRAC_BITS   = 16;
	localparam int LIMIT_CYCLES = 400000;
	localparam int LONG_STALL  = 300;

	typedef struct packed {
		logic [7:0] value;
		logic       kind;
		logic       last;
	} text_item_t;

	typedef struct packed {
		logic [30:0] int_value;
		logic [31:0] fixed_value;
		logic        ran_out;
		logic        saturated;
	} scan_token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  byte_value = 8'd0;
	logic        number_kind = 1'b0;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [30:0] int_value;
	logic [31:0] fixed_value;
	logic        ran_out;
	logic        saturated;

	text_item_t  pending_items[$];
	scan_token_t expected_tokens[$];
	scan_token_t want;
	text_item_t  next_item;

	// predicted scanner state
	scan_mode_t  mode_m = SCAN_IDLE;
	logic [31:0] int_acc = '0;
	logic [29:0] frac_acc = '0;
	logic [3:0]  frac_cnt = '0;
	logic [1:0]  points = '0;
	logic        ovf = 1'b0;

	logic in_fire = 1'b0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   rx_stall_go = 0;
	int   rx_stall_left = 0;
	int   items_queued = 0;
	int   items_sent = 0;
	int   tokens_checked = 0;
	int   sat_seen = 0;
	int   ran_out_seen = 0;
	int   mismatch_count = 0;
	int   cycle_count = 0;

	decimal_number_token_scanner_unit #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_value(byte_value),
		.number_kind(number_kind),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.int_value(int_value),
		.fixed_value(fixed_value),
		.ran_out(ran_out),
		.saturated(saturated)
	);

	always #4 clk = ~clk;

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	task automatic clear_acc();
		int_acc = '0;
		frac_acc = '0;
		frac_cnt = '0;
		points = '0;
		ovf = 1'b0;
	endtask

	task automatic take_digit(input logic [7:0] b);
		logic [35:0] v;
		if (points == 2'd0) begin
			if (!ovf) begin
				v = {4'd0, int_acc} * 36'd10 + 36'(b - CH_ZERO);
				if (v > 36'(INT_MAX_VAL)) begin
					ovf = 1'b1;
					int_acc = 32'(INT_MAX_VAL);
				end else begin
					int_acc = v[31:0];
				end
			end
		end else if (points == 2'd1 && frac_cnt < MAX_FRAC_DIGITS) begin
			frac_acc = frac_acc * 30'd10 + 30'(b - CH_ZERO);
			frac_cnt = frac_cnt + 4'd1;
		end
	endtask

	task automatic start_or_skip(input logic [7:0] b);
		if (b == CH_SLASH) begin
			mode_m = SCAN_SLASH;
		end else if (is_digit(b)) begin
			clear_acc();
			take_digit(b);
			mode_m = SCAN_NUMBER;
		end
	endtask

	function automatic scan_token_t finish_token(input logic kind);
		scan_token_t t;
		logic [63:0] scale;
		logic [63:0] frac;
		logic        big;
		scale = 64'd1;
		for (int i = 0; i < frac_cnt; i++)
			scale = scale * 64'd10;
		frac = ({34'd0, frac_acc} << FRAC_BITS) / scale;
		big = ovf || int_acc > ((32'd1 << (32 - FRAC_BITS)) - 32'd1);
		t.int_value = int_acc[30:0];
		t.fixed_value = big ? 32'hFFFF_FFFF : 32'(({32'd0, int_acc} << FRAC_BITS) | frac);
		t.ran_out = 1'b0;
		t.saturated = kind ? big : ovf;
		return t;
	endfunction

	task automatic predict_scan(input logic [7:0] b, input logic kind, input logic last);
		logic        produced;
		scan_token_t t;
		produced = 1'b0;
		case (mode_m)
			SCAN_SLASH: begin
				if (b == CH_SLASH) begin
					mode_m = SCAN_COMMENT;
				end else begin
					mode_m = SCAN_IDLE;
					start_or_skip(b);
				end
			end
			SCAN_COMMENT: begin
				if (b == CH_NEWLINE)
					mode_m = SCAN_IDLE;
			end
			SCAN_NUMBER: begin
				if (is_digit(b)) begin
					take_digit(b);
				end else if (b == CH_POINT && kind) begin
					if (points < 2'd2)
						points = points + 2'd1;
				end else begin
					expected_tokens.push_back(finish_token(kind));
					produced = 1'b1;
					mode_m = SCAN_IDLE;
					clear_acc();
				end
			end
			default: begin
				start_or_skip(b);
			end
		endcase
		if (last) begin
			if (!produced) begin
				t = '0;
				t.ran_out = 1'b1;
				expected_tokens.push_back(t);
			end
			mode_m = SCAN_IDLE;
			clear_acc();
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic kind, input logic last);
		text_item_t it;
		it.value = b;
		it.kind = kind;
		it.last = last;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic queue_text(input string s, input logic kind);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i], kind, 1'b0);
	endtask

	task automatic queue_digit(input logic kind);
		queue_byte(CH_ZERO + 8'($urandom_range(9)), kind, 1'b0);
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int count,
			input bit squeeze);
		int         target;
		int         n;
		int         m;
		int         pick;
		logic       kind;
		logic [7:0] b;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		if (squeeze)
			rx_stall_go = 1;
		target = items_queued + count;
		while (items_queued < target) begin
			pick = $urandom_range(99);
			kind = 1'($urandom_range(1));
			if (pick < 55) begin
				// number token, mostly short, sometimes past the saturation point
				n = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 5);
				repeat (n) queue_digit(kind);
				if (kind && $urandom_range(3) != 0) begin
					queue_byte(CH_POINT, kind, 1'b0);
					m = ($urandom_range(5) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 4);
					repeat (m) queue_digit(kind);
					if ($urandom_range(7) == 0) begin
						queue_byte(CH_POINT, kind, 1'b0);
						repeat ($urandom_range(0, 3)) queue_digit(kind);
					end
				end
				case ($urandom_range(3))
					0: b = 8'h20;
					1: b = CH_NEWLINE;
					2: b = CH_SLASH;
					default: begin
						do
							b = 8'($urandom_range(255));
						while (is_digit(b) || (kind && b == CH_POINT));
					end
				endcase
				queue_byte(b, kind, $urandom_range(9) == 0);
			end else if (pick < 67) begin
				queue_text("//", kind);
				repeat ($urandom_range(0, 6)) begin
					do
						b = 8'($urandom_range(255));
					while (b == CH_NEWLINE);
					queue_byte(b, kind, 1'b0);
				end
				queue_byte(CH_NEWLINE, kind, $urandom_range(15) == 0);
			end else if (pick < 73) begin
				queue_byte(CH_SLASH, kind, 1'b0);
				queue_byte(8'($urandom_range(255)), kind, $urandom_range(7) == 0);
			end else if (pick < 78) begin
				// buffer ends inside a token
				repeat ($urandom_range(0, 3)) queue_digit(kind);
				queue_byte(CH_ZERO + 8'($urandom_range(9)), kind, 1'b1);
			end else begin
				queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
					$urandom_range(15) == 0);
			end
		end
		drain();
	endtask

	// driver
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (pending_items.size() != 0 && rx_stall_go == 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				in_valid <= 1'b1;
				byte_value <= next_item.value;
				number_kind <= next_item.kind;
				is_last <= next_item.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (rx_stall_go != 0) begin
			rx_stall_left = LONG_STALL;
			rx_stall_go = 0;
		end
		if (rx_stall_left > 0) begin
			out_ready <= 1'b0;
			rx_stall_left--;
		end else begin
			out_ready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result: int %0d fixed %h ran_out %b sat %b",
						int_value, fixed_value, ran_out, saturated);
				mismatch_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (int_value !== want.int_value || fixed_value !== want.fixed_value ||
						ran_out !== want.ran_out || saturated !== want.saturated) begin
					if (mismatch_count < 10) begin
						$display("token %0d expected: int %0d fixed %h ran_out %b sat %b",
							tokens_checked, want.int_value, want.fixed_value,
							want.ran_out, want.saturated);
						$display("token %0d actual:   int %0d fixed %h ran_out %b sat %b",
							tokens_checked, int_value, fixed_value, ran_out, saturated);
					end
					mismatch_count++;
				end
				tokens_checked++;
				if (want.saturated)
					sat_seen++;
				if (want.ran_out)
					ran_out_seen++;
			end
		end
		if (in_valid && in_ready) begin
			predict_scan(byte_value, number_kind, is_last);
			items_sent++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		send_idle_pct = 21;
		recv_idle_pct = 72;
		// stray slash, second point, slash as terminator
		queue_text("/5.2.7/", 1'b1);
		queue_text("//", 1'b0);
		queue_byte(8'hFF, 1'b1, 1'b0);
		queue_byte(CH_NEWLINE, 1'b0, 1'b0);
		// point ends an integer request
		queue_text("9.", 1'b0);
		// large integer part with an overlong fraction
		queue_text("70000.1234567891;", 1'b1);
		// terminator on the final byte, then a token cut short, then a final slash
		queue_byte(CH_ZERO, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b1);
		queue_byte(CH_ZERO + 8'd4, 1'b1, 1'b1);
		queue_byte(CH_SLASH, 1'b0, 1'b1);
		drain();

		run_phase(21, 72, 330, 1'b0);
		run_phase(72, 21, 330, 1'b0);
		run_phase(0, 0, 330, 1'b1);

		repeat (FRAC_BITS + 20) @(posedge clk);
		if (expected_tokens.size() != 0)
			mismatch_count += expected_tokens.size();
		$display("%0d text bytes sent, %0d results checked", items_sent, tokens_checked);
		$display("%0d saturated tokens, %0d buffer ends without a token", sat_seen,
			ran_out_seen);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
